/* rtl/hs_pkg.sv */
package hs_pkg;

  // Element store geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // Child index of a heap node: 2*node+2 can reach 2^(ADDR_W+1)
  localparam int unsigned CHLD_W = ADDR_W + 2;

endpackage

/* rtl/heap_sorter_unit.sv */
// Heap sorter. Collect signed 32-bit items on the slave stream, one per cycle, into an
// element store of hs_pkg::DEPTH entries until an item with tlast arrives. Then sort the
// set in place by heap sort and stream it out on the master side: ascending by default
// (max-heap), descending when the configuration bit is set (min-heap); tlast marks the
// final item of the run. Items arriving after the store is full are dropped; every item
// of such a run leaves with tuser set, and an item with tlast still closes the run even
// when its value is dropped. Write the configuration bit only between runs. The block
// takes no input while it sorts or streams out, and takes the next set as soon as the
// final sorted item sits in the output register. A run of n items is first loaded; the sort
// then works through the single read port of the store, each sift level reading the left
// child, reading the right child, then comparing and writing back, over n/2 build sifts
// and n-1 extraction sifts, each set up by ST_BRD and ST_BCUR (build) or by ST_XRD0,
// ST_XRD1 and ST_XWR (extraction); the output then reads each element and loads it into
// the output register, and waits while the sink stalls. No clearing pass follows reset:
// only written entries are ever read.
module heap_sorter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: descending order select
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [hs_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic                      s_axis_tlast,   // last
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [hs_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic                      m_axis_tlast,   // last_res
  output logic                      m_axis_tuser    // [0] overflow
);
  import hs_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_LOAD = 4'd0;   // collect items
  localparam logic [3:0] ST_BRD  = 4'd1;   // build: read the node to sift
  localparam logic [3:0] ST_BCUR = 4'd2;   // build: capture it
  localparam logic [3:0] ST_XRD0 = 4'd3;   // extract: read the root
  localparam logic [3:0] ST_XRD1 = 4'd4;   // extract: capture root, read tail
  localparam logic [3:0] ST_XWR  = 4'd5;   // extract: root to tail, sift tail value
  localparam logic [3:0] ST_SFL  = 4'd6;   // sift: read left child
  localparam logic [3:0] ST_SFR  = 4'd7;   // sift: take left, read right child
  localparam logic [3:0] ST_SFC  = 4'd8;   // sift: pick the best of three
  localparam logic [3:0] ST_ORD  = 4'd9;   // output: read next element
  localparam logic [3:0] ST_OLD  = 4'd10;  // output: load output register

  // True when a should sit above b in the heap
  function automatic logic ranks_above(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b,
                                       input logic              min_heap);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    return min_heap ? lt : gt;
  endfunction

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic              desc_q;
  logic [CNT_W-1:0]  idx_q, idx_d;     // sift counter, then output index
  logic              build_q, build_d; // sift belongs to the build phase
  logic [ADDR_W-1:0] node_q, node_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [DATA_W-1:0] cur_q, cur_d;     // value being sifted down
  logic [DATA_W-1:0] top_q, top_d;     // root held during extraction
  logic [DATA_W-1:0] lval_q, lval_d;   // left child value
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  logic              m_last_q, m_last_d;
  logic              m_user_q, m_user_d;

  // Element store
  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [CHLD_W-1:0] left_idx, right_idx, size_ext;
  logic [CNT_W-1:0]  idx_m1, cnt_inc, cnt_n;
  logic              in_acc, sift_ret, left_up, right_up;
  logic [DATA_W-1:0] best_v;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign left_idx  = {1'b0, node_q, 1'b1};
  assign right_idx = left_idx + CHLD_W'(1);
  assign size_ext  = CHLD_W'(size_q);
  assign idx_m1    = idx_q - CNT_W'(1);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign cnt_n     = (cnt_q < CNT_W'(DEPTH)) ? cnt_inc : cnt_q;
  assign left_up   = ranks_above(lval_q, cur_q, desc_q);
  assign best_v    = left_up ? lval_q : cur_q;
  assign right_up  = ranks_above(rdata_q, best_v, desc_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    idx_d     = idx_q;
    build_d   = build_q;
    node_d    = node_q;
    size_d    = size_q;
    cur_d     = cur_q;
    top_d     = top_q;
    lval_d    = lval_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_user_d  = m_user_q;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = node_q;
    wr_data   = cur_q;
    sift_ret  = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          // Store while there is room, else drop and flag the run
          if (cnt_q < CNT_W'(DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[ADDR_W-1:0];
            wr_data = s_axis_tdata;
            cnt_d   = cnt_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            if (cnt_n >= CNT_W'(2)) begin
              idx_d   = cnt_n >> 1;
              build_d = 1'b1;
              state_d = ST_BRD;
            end else begin
              idx_d   = '0;
              state_d = ST_ORD;
            end
          end
        end
      end
      ST_BRD: begin
        rd_addr = idx_m1[ADDR_W-1:0];
        node_d  = idx_m1[ADDR_W-1:0];
        state_d = ST_BCUR;
      end
      ST_BCUR: begin
        cur_d   = rdata_q;
        size_d  = cnt_q;
        state_d = ST_SFL;
      end
      ST_XRD0: begin
        rd_addr = '0;
        state_d = ST_XRD1;
      end
      ST_XRD1: begin
        top_d   = rdata_q;
        rd_addr = idx_m1[ADDR_W-1:0];
        state_d = ST_XWR;
      end
      ST_XWR: begin
        // Move the root to the tail, sift the old tail value from the root
        cur_d   = rdata_q;
        wr_en   = 1'b1;
        wr_addr = idx_m1[ADDR_W-1:0];
        wr_data = top_q;
        node_d  = '0;
        size_d  = idx_m1;
        state_d = ST_SFL;
      end
      ST_SFL: begin
        if (left_idx < size_ext) begin
          rd_addr = left_idx[ADDR_W-1:0];
          state_d = ST_SFR;
        end else begin
          wr_en    = 1'b1;
          sift_ret = 1'b1;
        end
      end
      ST_SFR: begin
        lval_d = rdata_q;
        if (right_idx < size_ext) begin
          rd_addr = right_idx[ADDR_W-1:0];
          state_d = ST_SFC;
        end else if (ranks_above(rdata_q, cur_q, desc_q)) begin
          wr_en   = 1'b1;
          wr_data = rdata_q;
          node_d  = left_idx[ADDR_W-1:0];
          state_d = ST_SFL;
        end else begin
          wr_en    = 1'b1;
          sift_ret = 1'b1;
        end
      end
      ST_SFC: begin
        wr_en = 1'b1;
        if (right_up) begin
          wr_data = rdata_q;
          node_d  = right_idx[ADDR_W-1:0];
          state_d = ST_SFL;
        end else if (left_up) begin
          wr_data = lval_q;
          node_d  = left_idx[ADDR_W-1:0];
          state_d = ST_SFL;
        end else begin
          sift_ret = 1'b1;
        end
      end
      ST_ORD: begin
        // Read only once the output register frees up
        if (!m_valid_q || m_axis_tready) begin
          rd_addr = idx_q[ADDR_W-1:0];
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        m_valid_d = 1'b1;
        m_data_d  = rdata_q;
        m_user_d  = drop_q;
        m_last_d  = (idx_q == cnt_q - CNT_W'(1));
        idx_d     = idx_q + CNT_W'(1);
        if (m_last_d) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_ORD;
        end
      end
      default: state_d = ST_LOAD;
    endcase

    // Advance the build or extraction loop after a finished sift
    if (sift_ret) begin
      if (build_q) begin
        if (idx_q == CNT_W'(1)) begin
          idx_d   = cnt_q;
          build_d = 1'b0;
          state_d = ST_XRD0;
        end else begin
          idx_d   = idx_m1;
          state_d = ST_BRD;
        end
      end else if (idx_q == CNT_W'(2)) begin
        idx_d   = '0;
        state_d = ST_ORD;
      end else begin
        idx_d   = idx_m1;
        state_d = ST_XRD0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      desc_q    <= 1'b0;
      idx_q     <= '0;
      build_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      idx_q     <= idx_d;
      build_q   <= build_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    size_q   <= size_d;
    cur_q    <= cur_d;
    top_q    <= top_d;
    lval_q   <= lval_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

/* rtl/hs_checker.sv */
module hs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [hs_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);
  import hs_pkg::*;

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  // The item that closes a set starts the sort, so input stops
  a_sort_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after the closing item");

  // While loading, only the final item of the previous run may wait
  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("non-final output pending while loading");

  // Inside a run the input stays closed
  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input opened in the middle of an output run");

endmodule

bind heap_sorter_unit hs_checker u_hs_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hs_pkg::*;

  // Longest stretch without any item moving on either side before the run is
  // declared hung. It sits well above a full DEPTH-entry sort and the long
  // receiver hold LONG_HOLD, so this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned NUM_DIRECT  = 23;
  localparam int unsigned MAX_PRINTS  = 40;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } elem_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_wdata_i   = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;    // [31:0] value
  logic              s_axis_tlast  = 1'b0;  // last
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;          // [31:0] sorted_value
  logic              m_axis_tlast;          // last_res
  logic              m_axis_tuser;          // [0] overflow

  heap_sorter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Items waiting to be offered, filled by the stimulus block.
  elem_item_t               pending[$];
  elem_item_t               next_elem;
  // Shadow of the block: elements of the open set, overflow mark, sort order.
  logic signed [DATA_W-1:0] loaded_vals[$];
  logic                     store_overflowed = 1'b0;
  logic                     order_desc       = 1'b0;
  // Sorted items still owed by the block, oldest first.
  sorted_word_t             sorted_due[$];

  int unsigned              send_idle_pct = 0;
  int unsigned              recv_idle_pct = 0;
  int unsigned              hold_reqs     = 0;
  int unsigned              hold_seen     = 0;
  int unsigned              hold_left     = 0;
  int unsigned              quiet_cycles  = 0;
  int unsigned              mismatches    = 0;
  logic [DATA_W-1:0]        prev_value    = '0;

  logic [DATA_W-1:0]        dir_vals [NUM_DIRECT];
  logic                     dir_last [NUM_DIRECT];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Close the open set: order it the way the block will and owe one result per
  // stored element. Equal values land next to each other, so any stable or
  // unstable sort gives the same output.
  task automatic emit_sorted_run();
    logic signed [DATA_W-1:0] run[$];
    logic signed [DATA_W-1:0] key;
    int                       i;
    int                       j;
    run = loaded_vals;
    for (i = 1; i < run.size(); i++) begin
      key = run[i];
      j   = i;
      while (j > 0 && (order_desc ? (run[j-1] < key) : (run[j-1] > key))) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = key;
    end
    for (i = 0; i < run.size(); i++) begin
      sorted_due.push_back('{value: run[i], last: (i == run.size() - 1),
                             ovf: store_overflowed});
    end
    loaded_vals.delete();
    store_overflowed = 1'b0;
  endtask

  // Take one accepted input item into the shadow; drop it once the store is full.
  task automatic load_element(input logic [DATA_W-1:0] value, input logic last);
    if (loaded_vals.size() < DEPTH) loaded_vals.push_back(value);
    else store_overflowed = 1'b1;
    if (last) emit_sorted_run();
  endtask

  task automatic check_result();
    sorted_word_t want;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("unexpected item %h last=%b ovf=%b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
    end else begin
      want = sorted_due.pop_front();
      if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
          m_axis_tuser !== want.ovf) begin
        report_mismatch($sformatf("got %h last=%b ovf=%b, want %h last=%b ovf=%b",
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser,
                                  want.value, want.last, want.ovf));
      end
    end
  endtask

  // Sender: hold the item until taken, then fetch the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) load_element(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_elem = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_elem.value;
          s_axis_tlast  <= next_elem.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every taken item, stall at random, and hold off for a long
  // stretch whenever the stimulus asks for one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_seen != hold_reqs) begin
        hold_seen     <= hold_reqs;
        hold_left     <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", quiet_cycles);
        $display("FAIL heap_sorter_unit");
        $finish;
      end
    end
  end

  // Mix of extremes, small values, repeats of the previous value and full-range
  // random words, so that duplicates and sign boundaries show up often.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1: v = $unsigned(32'($signed($urandom_range(0, 16)) - 8));
      2: v = prev_value;
      default: v = $urandom;
    endcase
    prev_value = v;
    return v;
  endfunction

  // Mostly short sets, some mid-size, a few that reach or pass the store depth.
  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 10);
    if (r < 94) return $urandom_range(11, 40);
    return $urandom_range(60, 70);
  endfunction

  task automatic queue_set(input int n);
    int k;
    for (k = 0; k < n; k++) pending.push_back('{value: pick_value(), last: (k == n - 1)});
  endtask

  task automatic queue_random_sets(input int items);
    int done;
    int n;
    done = 0;
    while (done < items) begin
      n = pick_run_len();
      queue_set(n);
      done += n;
    end
  endtask

  // Block until the sender has nothing left and every owed result has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || sorted_due.size() != 0);
  endtask

  // Write the order bit while the block is idle; let it settle first.
  task automatic write_order(input logic desc);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    order_desc = desc;
    @(negedge clk_i);
  endtask

  initial begin
    // Directed sets: sign extremes alone, extremes mixed with neighbors,
    // repeated values, an all-equal pair, an already ordered run.
    dir_vals = '{32'h8000_0000,
                 32'h7fff_ffff,
                 32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000,
                 32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe,
                 32'h0000_0005, 32'hffff_fffd, 32'h0000_0005, 32'h0000_0005,
                 32'hffff_fffd, 32'h0000_0000,
                 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_fffe, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
                 32'h0000_0002, 32'h0000_0003};
    dir_last = '{1'b1,
                 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b0, 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ascending, directed sets; sender idles lightly, receiver stalls often.
    write_order(1'b0);
    send_idle_pct = 24;
    recv_idle_pct = 50;
    for (int i = 0; i < NUM_DIRECT; i++)
      pending.push_back('{value: dir_vals[i], last: dir_last[i]});
    wait_drained();

    // Descending: a set that exactly fills the store, then random sets.
    write_order(1'b1);
    queue_set(DEPTH);
    queue_random_sets(100);
    wait_drained();

    // Ascending with the idle rates swapped. Open with a set whose final item
    // is dropped, and hold the receiver off while sets keep coming so that the
    // block backs up into its input.
    write_order(1'b0);
    send_idle_pct = 50;
    recv_idle_pct = 24;
    queue_set(DEPTH + 2);
    queue_random_sets(50);
    hold_reqs++;
    // Queue nothing more until every owed result is out, then resume.
    wait_drained();
    queue_random_sets(60);
    wait_drained();

    // Descending at full rate on both sides.
    write_order(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_sets(100);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (sorted_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sorted_due.size()));
    if (mismatches == 0) begin
      $display("PASS heap_sorter_unit");
    end else begin
      $display("FAIL heap_sorter_unit");
    end
    $finish;
  end

endmodule
